[sv/dfoa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfoa_pkg
// Shared types and constants for the dual-channel overlap-add FIR core.
// ----------------------------------------------------------------------------
package dfoa_pkg;

   localparam int TAPS      = 6;
   localparam int DELAY_LEN = TAPS - 1;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 32;
   localparam int POS_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   // block position saturates here; at this position all products count to the current block
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(TAPS - 1);
   // number of tap registers in the register map
   localparam logic [CSR_IDX_W:0] CSR_NUM_REGS = (CSR_IDX_W + 1)'(TAPS);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic [POS_W-1:0]           pos_type;
   typedef sample_type [TAPS-1:0]      tap_set_type;

   // control from the top level to each lane
   typedef struct packed {
      logic    load;   // an item is accepted this cycle
      pos_type pos;    // block position of the item held in the product stage
   } lane_ctl_type;

   // handshake status between merge stage and top level
   typedef struct packed {
      logic take;      // product stage moves into the output register
   } merge_stat_type;

endpackage : dfoa_pkg
`default_nettype wire

[sv/dual_fir_overlap_add_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_fir_overlap_add_core
// Two-channel 6-tap Q15 FIR with block-wise overlap-add, one lane per channel.
//
//   channel | direction | payload
//   req_    | in        | tdata: sample_a [15:0], sample_b [31:16]; tlast: block_end
//   rsp_    | out       | tdata: out_a [15:0], out_b [31:16]
//   csr_    | in        | index: tap register 0..5; data: tap pair (a low, b high)
//
// One item per cycle sustained unless the output stalls; each item passes
// the product register, then the output register after the split sum and merge.
// Reset clears taps, delay lines, block position and valid flags at once.
// A stalled output holds its item; the product stage keeps loading while the
// output register drains, so input is held only when both stages are full.
// ----------------------------------------------------------------------------
module dual_fir_overlap_add_core import dfoa_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [2*SAMPLE_W-1:0] req_tdata,   // sample_a [15:0], sample_b [31:16]
   input  wire logic                  req_tlast,   // block_end
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [2*SAMPLE_W-1:0]      rsp_tdata,   // out_a [15:0], out_b [31:16]
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   tap_set_type    taps_a_ff;
   tap_set_type    taps_b_ff;
   pos_type        pos_ff;
   pos_type        pos_in;
   pos_type        stage_pos_ff;
   logic           stage_valid_ff;
   logic           req_accept;
   lane_ctl_type   ctl;
   merge_stat_type stat;
   sample_type     lane_a;
   sample_type     lane_b;

   // write tap registers; indexes past the map are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_a_ff <= '0;
         taps_b_ff <= '0;
      end else if (csr_valid && ({1'b0, csr_index} < CSR_NUM_REGS)) begin
         taps_a_ff[csr_index] <= sample_type'(csr_data[SAMPLE_W-1:0]);
         taps_b_ff[csr_index] <= sample_type'(csr_data[2*SAMPLE_W-1:SAMPLE_W]);
      end
   end

   // accept when the product stage is empty or moves on this cycle
   assign req_tready = !stage_valid_ff || stat.take;
   assign req_accept = req_tvalid && req_tready;

   // advance the block position, saturating, restart after a block end
   always_comb begin
      pos_in = pos_ff;
      if (req_accept) begin
         if (req_tlast) begin
            pos_in = '0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (req_accept) begin
            stage_valid_ff <= 1'b1;
         end else if (stat.take) begin
            stage_valid_ff <= 1'b0;
         end
      end
   end

   // carry the item's position alongside its products
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_pos_ff <= pos_ff;
      end
   end

   assign ctl.load = req_accept;
   assign ctl.pos  = stage_pos_ff;

   dfoa_lane u_lane_a (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_in  (sample_type'(req_tdata[SAMPLE_W-1:0])),
      .taps       (taps_a_ff),
      .sample_out (lane_a)
   );

   dfoa_lane u_lane_b (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_in  (sample_type'(req_tdata[2*SAMPLE_W-1:SAMPLE_W])),
      .taps       (taps_b_ff),
      .sample_out (lane_b)
   );

   dfoa_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid_ff),
      .lane_a      (lane_a),
      .lane_b      (lane_b),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .stat        (stat)
   );

   // position never passes its saturation point
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("block position out of range");

   // a block end restarts the position
   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (pos_ff == '0))
      else $error("block position not cleared after block end");

   // an accepted item always lands in the product stage
   a_stage_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> stage_valid_ff)
      else $error("accepted item lost before product stage");

   // a held product stage is not overwritten
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !stat.take) |-> !req_tready)
      else $error("input accepted over a stalled product stage");

endmodule : dual_fir_overlap_add_core
`default_nettype wire

[sv/dfoa_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfoa_lane
// One channel: delay line, six registered tap products, and the split sum
// into current-block and tail parts combined with 16-bit wrap.
// ----------------------------------------------------------------------------
module dfoa_lane import dfoa_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire lane_ctl_type ctl,
   input  wire sample_type   sample_in,
   input  wire tap_set_type  taps,
   output sample_type        sample_out
);

   sample_type [DELAY_LEN-1:0] delay_ff;
   prod_type   [TAPS-1:0]      prod_ff;
   logic       [PROD_W-1:0]    cur_sum;
   logic       [PROD_W-1:0]    tail_sum;

   // shift the delay line on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= '0;
      end else if (ctl.load) begin
         delay_ff <= {delay_ff[DELAY_LEN-2:0], sample_in};
      end
   end

   // form one product per tap from the newest sample and the delay taps
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         prod_ff[0] <= prod_type'(sample_in) * prod_type'(taps[0]);
         for (int k = 1; k < TAPS; k++) begin
            prod_ff[k] <= prod_type'(delay_ff[k-1]) * prod_type'(taps[k]);
         end
      end
   end

   // split products into current-block and previous-block groups
   always_comb begin
      cur_sum  = '0;
      tail_sum = '0;
      for (int k = 0; k < TAPS; k++) begin
         if (POS_W'(k) <= ctl.pos) begin
            cur_sum = cur_sum + prod_ff[k];
         end else begin
            tail_sum = tail_sum + prod_ff[k];
         end
      end
   end

   // drop fraction bits of each part and add with wrap
   assign sample_out = sample_type'(cur_sum[SAMPLE_W+14:15] + tail_sum[SAMPLE_W+14:15]);

endmodule : dfoa_lane
`default_nettype wire

[sv/dfoa_merge.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfoa_merge
// Merge stage: packs both lane results into one item and holds it in the
// output register until the consumer takes it.
// ----------------------------------------------------------------------------
module dfoa_merge import dfoa_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             stage_valid,
   input  wire sample_type       lane_a,
   input  wire sample_type       lane_b,
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic [2*SAMPLE_W-1:0] rsp_tdata,
   output merge_stat_type        stat
);

   logic                  valid_ff;
   logic                  valid_in;
   logic [2*SAMPLE_W-1:0] data_ff;

   // load when the register is empty or drained this cycle
   assign stat.take = stage_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (stat.take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the packed item while stalled
   always_ff @(posedge clock) begin
      if (stat.take) begin
         data_ff <= {lane_b, lane_a};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule : dfoa_merge
`default_nettype wire
